// File: hdl/rotation_matrix_to_quaternion_assert.svh
// assertion macros for the rotation matrix to quaternion block
// used by the port checker; needs nothing else
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RMQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RMQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rmq_pkg.sv
// shared types and constants of the rotation matrix to quaternion pipeline
// no dependencies
package rmq_pkg;

  localparam int SqrtSteps = 16;
  localparam int DivSteps  = 17;

  localparam logic [14:0] TolReset = 15'd1638;
  localparam logic [15:0] SatMax   = 16'h7fff;
  localparam logic [15:0] SatMin   = 16'h8000;

  typedef enum logic [2:0] {
    BR_TRACE = 3'd0,
    BR_X     = 3'd1,
    BR_Y     = 3'd2,
    BR_Z     = 3'd3,
    BR_NONE  = 3'd4
  } branch_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  // numerators and branch hints carried alongside the square roots
  typedef struct packed {
    logic               trace_pos;
    axis_e              first;
    logic signed [16:0] d1;   // r21 - r12
    logic signed [16:0] d2;   // r02 - r20
    logic signed [16:0] d3;   // r10 - r01
    logic signed [16:0] p01;  // r01 + r10
    logic signed [16:0] p02;  // r02 + r20
    logic signed [16:0] p12;  // r12 + r21
  } num_t;

  // what the output stage needs to place the divider lanes
  typedef struct packed {
    branch_e     br;
    logic [14:0] half;
  } route_t;

endpackage

// File: hdl/rmq_sqrt.sv
// four-lane pipelined integer square root, one result bit per stage
// depends on rmq_pkg
module rmq_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [3:0][30:0]     rad_i,
  input  rmq_pkg::num_t        side_i,
  output logic                 vld_o,
  output logic [3:0][15:0]     root_o,
  output rmq_pkg::num_t        side_o
);
  import rmq_pkg::*;

  logic [SqrtSteps-1:0] vld_q;
  logic [3:0][31:0]     rest_q [SqrtSteps-1];
  logic [3:0][16:0]     rem_q  [SqrtSteps-1];
  logic [3:0][15:0]     root_q [SqrtSteps];
  num_t                 side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic             cur_vld;
    logic [3:0][31:0] cur_rest;
    logic [3:0][16:0] cur_rem;
    logic [3:0][15:0] cur_root;
    num_t             cur_side;
    logic [3:0][31:0] rest_d;
    logic [3:0][16:0] rem_d;
    logic [3:0][15:0] root_d;

    if (k == 0) begin : g_first
      always_comb begin
        cur_vld  = vld_i;
        cur_side = side_i;
        cur_rem  = '0;
        cur_root = '0;
        for (int l = 0; l < 4; l++) begin
          cur_rest[l] = {1'b0, rad_i[l]};
        end
      end
    end else begin : g_next
      assign cur_vld  = vld_q[k-1];
      assign cur_side = side_q[k-1];
      assign cur_rem  = rem_q[k-1];
      assign cur_root = root_q[k-1];
      assign cur_rest = rest_q[k-1];
    end

    always_comb begin : p_step
      logic [18:0] r2;
      logic [18:0] trial;
      logic [18:0] diff;
      for (int l = 0; l < 4; l++) begin
        r2        = {cur_rem[l], cur_rest[l][31:30]};
        trial     = {1'b0, cur_root[l], 2'b01};
        diff      = r2 - trial;
        rest_d[l] = {cur_rest[l][29:0], 2'b00};
        if (r2 >= trial) begin
          rem_d[l]  = diff[16:0];
          root_d[l] = {cur_root[l][14:0], 1'b1};
        end else begin
          rem_d[l]  = r2[16:0];
          root_d[l] = {cur_root[l][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_d;
        side_q[k] <= cur_side;
      end
    end

    if (k < SqrtSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rest_q[k] <= rest_d;
          rem_q[k]  <= rem_d;
        end
      end
    end
  end

  assign vld_o  = vld_q[SqrtSteps-1];
  assign root_o = root_q[SqrtSteps-1];
  assign side_o = side_q[SqrtSteps-1];

endmodule

// File: hdl/rmq_select.sv
// branch choice against the root tolerance and numerator routing, one stage
// depends on rmq_pkg
module rmq_select (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [3:0][15:0]      root_i,
  input  rmq_pkg::num_t         side_i,
  input  logic [14:0]           tol_i,
  output logic                  vld_o,
  output logic [15:0]           div_o,
  output logic [2:0][16:0]      num_o,
  output rmq_pkg::route_t       route_o
);
  import rmq_pkg::*;

  logic              vld_q;
  logic [15:0]       div_q, div_d;
  logic [2:0][16:0]  num_q, num_d;
  route_t            route_q, route_d;
  logic              ok_x, ok_y, ok_z;
  branch_e           br;

  // lane 0 trace, 1 x, 2 y, 3 z
  assign ok_x = root_i[1] > {1'b0, tol_i};
  assign ok_y = root_i[2] > {1'b0, tol_i};
  assign ok_z = root_i[3] > {1'b0, tol_i};

  always_comb begin
    br = BR_NONE;
    if (side_i.trace_pos) begin
      br = BR_TRACE;
    end else begin
      case (side_i.first)
        AX_X: begin
          br = ok_x ? BR_X : ok_z ? BR_Z : ok_y ? BR_Y : BR_NONE;
        end
        AX_Y: begin
          br = ok_y ? BR_Y : ok_z ? BR_Z : ok_x ? BR_X : BR_NONE;
        end
        AX_Z: begin
          br = ok_z ? BR_Z : ok_x ? BR_X : ok_y ? BR_Y : BR_NONE;
        end
        default: begin
          br = BR_NONE;
        end
      endcase
    end
  end

  always_comb begin
    div_d = 16'd1;
    num_d = '0;
    case (br)
      BR_TRACE: begin
        div_d = root_i[0];
        num_d = {side_i.d3, side_i.d2, side_i.d1};
      end
      BR_X: begin
        div_d = root_i[1];
        num_d = {side_i.p02, side_i.p01, side_i.d1};
      end
      BR_Y: begin
        div_d = root_i[2];
        num_d = {side_i.p01, side_i.p12, side_i.d2};
      end
      BR_Z: begin
        div_d = root_i[3];
        num_d = {side_i.p12, side_i.p02, side_i.d3};
      end
      default: begin
        div_d = 16'd1;
        num_d = '0;
      end
    endcase
    route_d.br   = br;
    route_d.half = (br == BR_NONE) ? 15'd0 : div_d[15:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q   <= div_d;
      num_q   <= num_d;
      route_q <= route_d;
    end
  end

  assign vld_o   = vld_q;
  assign div_o   = div_q;
  assign num_o   = num_q;
  assign route_o = route_q;

endmodule

// File: hdl/rmq_div.sv
// three-lane pipelined restoring divider for d*8192/s, one quotient bit per stage
// depends on rmq_pkg
module rmq_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [15:0]           div_i,
  input  logic [2:0][16:0]      num_i,
  input  rmq_pkg::route_t       route_i,
  output logic                  vld_o,
  output logic [2:0][16:0]      quo_o,
  output logic [2:0]            neg_o,
  output logic [2:0]            ovf_o,
  output rmq_pkg::route_t       route_o
);
  import rmq_pkg::*;

  // front stage: magnitude, overflow check on the upper dividend bits
  logic              pv_q;
  logic [2:0][15:0]  prem_q, prem_d;
  logic [2:0][16:0]  pacc_q, pacc_d;
  logic [2:0]        pneg_q, pneg_d;
  logic [2:0]        povf_q, povf_d;
  logic [15:0]       pdiv_q;
  route_t            proute_q;

  always_comb begin : p_front
    logic [16:0] mag;
    for (int l = 0; l < 3; l++) begin
      pneg_d[l] = num_i[l][16];
      mag       = pneg_d[l] ? 17'(17'd0 - num_i[l]) : num_i[l];
      prem_d[l] = {3'd0, mag[16:4]};
      pacc_d[l] = {mag[3:0], 13'd0};
      povf_d[l] = prem_d[l] >= div_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prem_q   <= prem_d;
      pacc_q   <= pacc_d;
      pneg_q   <= pneg_d;
      povf_q   <= povf_d;
      pdiv_q   <= div_i;
      proute_q <= route_i;
    end
  end

  logic [DivSteps-1:0] vld_q;
  logic [2:0][16:0]    acc_q   [DivSteps];
  logic [2:0]          neg_q   [DivSteps];
  logic [2:0]          ovf_q   [DivSteps];
  route_t              route_q [DivSteps];
  logic [2:0][15:0]    rem_q   [DivSteps-1];
  logic [15:0]         div_q   [DivSteps-1];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic             cur_vld;
    logic [2:0][15:0] cur_rem;
    logic [2:0][16:0] cur_acc;
    logic [2:0]       cur_neg;
    logic [2:0]       cur_ovf;
    logic [15:0]      cur_div;
    route_t           cur_route;
    logic [2:0][15:0] rem_d;
    logic [2:0][16:0] acc_d;

    if (k == 0) begin : g_first
      assign cur_vld   = pv_q;
      assign cur_rem   = prem_q;
      assign cur_acc   = pacc_q;
      assign cur_neg   = pneg_q;
      assign cur_ovf   = povf_q;
      assign cur_div   = pdiv_q;
      assign cur_route = proute_q;
    end else begin : g_next
      assign cur_vld   = vld_q[k-1];
      assign cur_rem   = rem_q[k-1];
      assign cur_acc   = acc_q[k-1];
      assign cur_neg   = neg_q[k-1];
      assign cur_ovf   = ovf_q[k-1];
      assign cur_div   = div_q[k-1];
      assign cur_route = route_q[k-1];
    end

    always_comb begin : p_step
      logic [16:0] r2;
      logic [16:0] diff;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        r2       = {cur_rem[l], cur_acc[l][16]};
        diff     = r2 - {1'b0, cur_div};
        ge       = r2 >= {1'b0, cur_div};
        rem_d[l] = ge ? diff[15:0] : r2[15:0];
        acc_d[l] = {cur_acc[l][15:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]   <= acc_d;
        neg_q[k]   <= cur_neg;
        ovf_q[k]   <= cur_ovf;
        route_q[k] <= cur_route;
      end
    end

    if (k < DivSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          div_q[k] <= cur_div;
        end
      end
    end
  end

  assign vld_o   = vld_q[DivSteps-1];
  assign quo_o   = acc_q[DivSteps-1];
  assign neg_o   = neg_q[DivSteps-1];
  assign ovf_o   = ovf_q[DivSteps-1];
  assign route_o = route_q[DivSteps-1];

endmodule

// File: hdl/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion, top level: input stage, sqrt, select, divide, output
// depends on rmq_pkg, rmq_sqrt, rmq_select, rmq_div
//
// One request on the slave stream carries a 3x3 matrix in signed Q2.14; one
// result on the master stream carries the quaternion w, x, y, z in signed
// Q2.14 (saturated) and in tuser the branch code: trace, x, y, z or none.
// root_tolerance is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while idle; the block does not enforce it. The pipeline has one input stage, 16
// square root stages (one root bit each), one branch select stage, one divider
// front stage, 17 divider stages (one quotient bit each) and the output register.
// All four square roots and all three quotients run in parallel lanes, so one matrix
// is taken per cycle unless the receiver stalls. The whole pipeline moves on one
// enable: it advances while the output register is empty or being taken; a stalled
// receiver freezes every stage and s_axis_tready drops, so nothing is lost or
// repeated. Reset clears all valid bits and loads root_tolerance with 1638.
module rotation_matrix_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [14:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, from bit 0)
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // qw, qx, qy, qz (16 bits each, from bit 0)
  output logic [63:0]   m_axis_tdata,
  // branch_used
  output logic [2:0]    m_axis_tuser
);
  import rmq_pkg::*;

  logic en;
  logic [14:0] tol_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // input stage: trace, radicands, numerators, first diagonal choice
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [17:0] t_sum, t_arg;
  logic signed [18:0] ax, ay, az;
  logic [3:0][30:0]   rad_d;
  num_t               side_d;

  assign r00 = s_axis_tdata[15:0];
  assign r01 = s_axis_tdata[31:16];
  assign r02 = s_axis_tdata[47:32];
  assign r10 = s_axis_tdata[63:48];
  assign r11 = s_axis_tdata[79:64];
  assign r12 = s_axis_tdata[95:80];
  assign r20 = s_axis_tdata[111:96];
  assign r21 = s_axis_tdata[127:112];
  assign r22 = s_axis_tdata[143:128];

  always_comb begin
    t_sum = 18'(r00) + 18'(r11) + 18'(r22);
    t_arg = t_sum + 18'sd16384;
    ax    = 19'(r00) - 19'(r11) - 19'(r22) + 19'sd16384;
    ay    = 19'(r11) - 19'(r22) - 19'(r00) + 19'sd16384;
    az    = 19'(r22) - 19'(r00) - 19'(r11) + 19'sd16384;

    side_d.trace_pos = t_sum > 18'sd0;
    // non-positive radicand gives a zero root, which never passes
    rad_d[0] = side_d.trace_pos ? {t_arg[16:0], 14'd0} : 31'd0;
    rad_d[1] = (ax > 19'sd0) ? {ax[16:0], 14'd0} : 31'd0;
    rad_d[2] = (ay > 19'sd0) ? {ay[16:0], 14'd0} : 31'd0;
    rad_d[3] = (az > 19'sd0) ? {az[16:0], 14'd0} : 31'd0;

    if (r00 > r11) begin
      side_d.first = (r22 > r00) ? AX_Z : AX_X;
    end else begin
      side_d.first = (r22 > r11) ? AX_Z : AX_Y;
    end

    side_d.d1  = 17'(r21) - 17'(r12);
    side_d.d2  = 17'(r02) - 17'(r20);
    side_d.d3  = 17'(r10) - 17'(r01);
    side_d.p01 = 17'(r01) + 17'(r10);
    side_d.p02 = 17'(r02) + 17'(r20);
    side_d.p12 = 17'(r12) + 17'(r21);
  end

  logic             in_vld_q;
  logic [3:0][30:0] rad_q;
  num_t             side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  logic             sq_vld;
  logic [3:0][15:0] sq_root;
  num_t             sq_side;

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_vld_q),
    .rad_i  (rad_q),
    .side_i (side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  logic             sel_vld;
  logic [15:0]      sel_div;
  logic [2:0][16:0] sel_num;
  route_t           sel_route;

  rmq_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sq_vld),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .tol_i   (tol_q),
    .vld_o   (sel_vld),
    .div_o   (sel_div),
    .num_o   (sel_num),
    .route_o (sel_route)
  );

  logic             dv_vld;
  logic [2:0][16:0] dv_quo;
  logic [2:0]       dv_neg;
  logic [2:0]       dv_ovf;
  route_t           dv_route;

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sel_vld),
    .div_i   (sel_div),
    .num_i   (sel_num),
    .route_i (sel_route),
    .vld_o   (dv_vld),
    .quo_o   (dv_quo),
    .neg_o   (dv_neg),
    .ovf_o   (dv_ovf),
    .route_o (dv_route)
  );

  // output stage: saturate the quotients and place lanes by branch
  logic [2:0][15:0] lane;
  logic [15:0]      half, qw_d, qx_d, qy_d, qz_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_neg[l]) begin
        lane[l] = (dv_ovf[l] || dv_quo[l] > 17'd32768) ? SatMin
                                                       : 16'(17'd0 - dv_quo[l]);
      end else begin
        lane[l] = (dv_ovf[l] || dv_quo[l] > 17'd32767) ? SatMax : dv_quo[l][15:0];
      end
    end
    half = {1'b0, dv_route.half};
    case (dv_route.br)
      BR_TRACE: begin
        qw_d = half;    qx_d = lane[0]; qy_d = lane[1]; qz_d = lane[2];
      end
      BR_X: begin
        qw_d = lane[0]; qx_d = half;    qy_d = lane[1]; qz_d = lane[2];
      end
      BR_Y: begin
        qw_d = lane[0]; qx_d = lane[2]; qy_d = half;    qz_d = lane[1];
      end
      BR_Z: begin
        qw_d = lane[0]; qx_d = lane[1]; qy_d = lane[2]; qz_d = half;
      end
      default: begin
        qw_d = '0;      qx_d = '0;      qy_d = '0;      qz_d = '0;
      end
    endcase
  end

  logic        out_vld_q;
  logic [63:0] out_data_q;
  logic [2:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {qz_d, qy_d, qx_d, qw_d};
      out_user_q <= dv_route.br;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: hdl/rmq_chk.sv
// port-level checker for the rotation matrix to quaternion block, with its bind
// depends on rmq_pkg and rotation_matrix_to_quaternion_assert.svh
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import rmq_pkg::*;

  logic        stall;
  logic        code_ok;
  logic        none_res;
  logic        all_zero;
  logic        diag_res;
  logic        root_neg;
  logic [67:0] res_bus;

  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign code_ok  = m_axis_tuser <= BR_NONE;
  assign none_res = m_axis_tvalid && (m_axis_tuser == BR_NONE);
  assign all_zero = m_axis_tdata == 64'd0;
  assign diag_res = m_axis_tvalid && (m_axis_tuser != BR_NONE);
  assign res_bus  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

  // the part taken from the root is half of it and never negative
  always_comb begin
    case (m_axis_tuser)
      BR_TRACE: begin
        root_neg = m_axis_tdata[15];
      end
      BR_X: begin
        root_neg = m_axis_tdata[31];
      end
      BR_Y: begin
        root_neg = m_axis_tdata[47];
      end
      BR_Z: begin
        root_neg = m_axis_tdata[63];
      end
      default: begin
        root_neg = 1'b0;
      end
    endcase
  end

  `RMQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall, $stable(res_bus), "result not held")

  `RMQ_ASSERT_IMP(a_branch_code, clk_i, rst_ni, m_axis_tvalid, code_ok, "bad branch code")

  `RMQ_ASSERT_IMP(a_none_zero, clk_i, rst_ni, none_res, all_zero, "none branch not zero")

  `RMQ_ASSERT_IMP(a_root_part, clk_i, rst_ni, diag_res, !root_neg, "root part negative")

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
